>>> sv/ps_pkg.sv
// Shared constants for the prime sieve block.
package ps_pkg;

    // Fixed widths of the request and result fields
    localparam int LIMIT_W = 9;
    localparam int VALUE_W = 8;

    // Smallest prime; entries below it are never candidates
    localparam int FIRST_PRIME = 2;

endpackage

>>> sv/ps_in_if.sv
// Request channel carrying the exclusive upper limit.
interface ps_in_if;

    logic                         valid;
    logic                         ready;
    logic [ps_pkg::LIMIT_W-1:0]   limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);

endinterface

>>> sv/ps_out_if.sv
// Result channel carrying the primes of each request, one prime per handshake.
interface ps_out_if;

    logic                         valid;
    logic                         ready;
    logic [ps_pkg::VALUE_W-1:0]   prime_value;
    logic                         found;
    logic                         last;

    modport source (output valid, output prime_value, output found, output last, input ready);
    modport sink   (input valid, input prime_value, input found, input last, output ready);

endinterface

>>> sv/ps_map.sv
// Candidate bitmap: one write port, one read port with registered data.
module ps_map #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/ps_alu.sv
// Shared step unit: add two indices and compare the sum against the bound.
module ps_alu #(
    parameter int LW = 9
) (
    input  logic [LW-1:0] a,
    input  logic [LW-1:0] b,
    input  logic [LW-1:0] bound,
    output logic [LW-1:0] sum,
    output logic          lt
);

    logic [LW:0] wide;

    assign wide = {1'b0, a} + {1'b0, b};
    assign sum  = wide[LW-1:0];
    assign lt   = wide < {1'b0, bound};

endmodule

>>> sv/prime_sieve_core.sv
// Prime sieve top level: sequencer around the bitmap and the shared step unit.
//
// Usage
//   limit_ch : request channel; each request carries an exclusive upper limit.
//              Limits above MAX_LIMIT are treated as MAX_LIMIT.
//   prime_ch : result channel; one result per prime below the limit, in
//              ascending order, with last set on the final one. A limit of two
//              or less yields a single result with found clear and last set.
//   A request is taken only while the block is idle; ready stays low from
//   acceptance until the final result has been loaded into the output register.
//   Clearing, striking and scanning take turns on the single bitmap port
//   pair and the one adder/comparator that every step of them uses.
//   When the receiver stalls, the output register holds its result and the
//   scan waits on the next prime it finds, so nothing is lost or repeated.
//   Reset clears the sequencer and output valid only; the bitmap needs no
//   clearing since each request rewrites every entry it later reads.
module prime_sieve_core #(
    parameter int MAX_LIMIT = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    ps_in_if.sink           limit_ch,
    ps_out_if.source        prime_ch
);

    localparam int AW = $clog2(MAX_LIMIT);
    localparam int LW = $clog2(MAX_LIMIT + 1);

    typedef enum logic [3:0] {
        IDLE,
        CLEAR,
        SIEVE_RD,
        SIEVE_CHK,
        STRIKE,
        SIEVE_NEXT,
        SCAN_RD,
        SCAN_CHK,
        FLUSH
    } state_t;

    state_t                     state_reg;
    logic [LW-1:0]              lim_reg;
    logic [LW-1:0]              i_reg;
    logic [LW-1:0]              j_reg;
    logic [AW-1:0]              pend_reg;
    logic                       have_pend_reg;

    logic                       out_valid_reg;
    logic [ps_pkg::VALUE_W-1:0] out_value_reg;
    logic                       out_found_reg;
    logic                       out_last_reg;

    // Bitmap port controls
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       wr_data;
    logic                       rd_en;
    logic                       rd_data;

    // Shared step unit
    logic [LW-1:0]              alu_a;
    logic [LW-1:0]              alu_b;
    logic [LW-1:0]              alu_sum;
    logic                       alu_lt;

    logic                       can_load;
    logic                       out_load;
    logic [LW-1:0]              lim_sat;

    // Saturate the requested limit to the bitmap depth
    assign lim_sat = (limit_ch.limit > ps_pkg::LIMIT_W'(MAX_LIMIT))
                   ? LW'(MAX_LIMIT) : LW'(limit_ch.limit);

    // The output register takes a new result once the old one has gone
    assign can_load = !out_valid_reg || prime_ch.ready;

    // Load a held prime when scanning finds the next one, or the final result
    assign out_load = can_load
                    && (((state_reg == SCAN_CHK) && rd_data && have_pend_reg)
                        || (state_reg == FLUSH));

    assign limit_ch.ready       = (state_reg == IDLE);
    assign prime_ch.valid       = out_valid_reg;
    assign prime_ch.prime_value = out_value_reg;
    assign prime_ch.found       = out_found_reg;
    assign prime_ch.last        = out_last_reg;

    always_comb
    begin
        wr_en   = (state_reg == CLEAR) || (state_reg == STRIKE);
        wr_addr = (state_reg == STRIKE) ? j_reg[AW-1:0] : i_reg[AW-1:0];
        // Clearing marks everything from the first prime upward; striking zeroes
        wr_data = (state_reg == CLEAR) && (i_reg >= LW'(ps_pkg::FIRST_PRIME));
        rd_en   = (state_reg == SIEVE_RD) || (state_reg == SCAN_RD);

        // Step j by i while striking or when starting from a live candidate,
        // otherwise advance i by one
        alu_a = (state_reg == STRIKE) ? j_reg : i_reg;
        if ((state_reg == STRIKE) || ((state_reg == SIEVE_CHK) && rd_data))
        begin
            alu_b = i_reg;
        end
        else
        begin
            alu_b = LW'(1);
        end
    end

    ps_map #(
        .DEPTH (MAX_LIMIT),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (i_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    ps_alu #(
        .LW (LW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .bound (lim_reg),
        .sum   (alu_sum),
        .lt    (alu_lt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            have_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a new result; drop it once the receiver has taken it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (prime_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (limit_ch.valid)
                    begin
                        lim_reg       <= lim_sat;
                        i_reg         <= '0;
                        have_pend_reg <= 1'b0;
                        // No prime below the limit: go straight to the empty answer
                        if (lim_sat <= LW'(ps_pkg::FIRST_PRIME))
                        begin
                            state_reg <= FLUSH;
                        end
                        else
                        begin
                            state_reg <= CLEAR;
                        end
                    end
                end

                CLEAR:
                begin
                    if (alu_lt)
                    begin
                        i_reg <= alu_sum;
                    end
                    else
                    begin
                        i_reg     <= LW'(ps_pkg::FIRST_PRIME);
                        state_reg <= SIEVE_RD;
                    end
                end

                SIEVE_RD:
                begin
                    state_reg <= SIEVE_CHK;
                end

                SIEVE_CHK:
                begin
                    if (rd_data)
                    begin
                        if (alu_lt)
                        begin
                            j_reg     <= alu_sum;
                            state_reg <= STRIKE;
                        end
                        else
                        begin
                            // Twice this prime is past the limit; so is every later one
                            i_reg     <= LW'(ps_pkg::FIRST_PRIME);
                            state_reg <= SCAN_RD;
                        end
                    end
                    else if (alu_lt)
                    begin
                        i_reg     <= alu_sum;
                        state_reg <= SIEVE_RD;
                    end
                    else
                    begin
                        i_reg     <= LW'(ps_pkg::FIRST_PRIME);
                        state_reg <= SCAN_RD;
                    end
                end

                STRIKE:
                begin
                    if (alu_lt)
                    begin
                        j_reg <= alu_sum;
                    end
                    else
                    begin
                        state_reg <= SIEVE_NEXT;
                    end
                end

                SIEVE_NEXT:
                begin
                    if (alu_lt)
                    begin
                        i_reg     <= alu_sum;
                        state_reg <= SIEVE_RD;
                    end
                    else
                    begin
                        i_reg     <= LW'(ps_pkg::FIRST_PRIME);
                        state_reg <= SCAN_RD;
                    end
                end

                SCAN_RD:
                begin
                    state_reg <= SCAN_CHK;
                end

                SCAN_CHK:
                begin
                    // Hold on a new prime while the previous one cannot be sent
                    if (!(rd_data && have_pend_reg && !can_load))
                    begin
                        if (rd_data)
                        begin
                            if (have_pend_reg)
                            begin
                                out_value_reg <= ps_pkg::VALUE_W'(pend_reg);
                                out_found_reg <= 1'b1;
                                out_last_reg  <= 1'b0;
                            end
                            pend_reg      <= i_reg[AW-1:0];
                            have_pend_reg <= 1'b1;
                        end
                        if (alu_lt)
                        begin
                            i_reg     <= alu_sum;
                            state_reg <= SCAN_RD;
                        end
                        else
                        begin
                            state_reg <= FLUSH;
                        end
                    end
                end

                FLUSH:
                begin
                    // Send the held prime as the final result, or the empty answer
                    if (can_load)
                    begin
                        out_value_reg <= have_pend_reg ? ps_pkg::VALUE_W'(pend_reg) : '0;
                        out_found_reg <= have_pend_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule
